### design/kscan_pkg.sv
// Shared types, constants and the fixed key table for the key scan autorepeat unit.
`timescale 1ns / 1ps

package kscan_pkg;

  localparam int WORD_W      = 32;
  localparam int KEY_W       = 5;
  localparam int DELAY_W     = 16;
  localparam int GROUP_W     = 2;
  localparam int MAX_GROUPS  = 4;
  localparam int INPUT_GROUPS = 3;
  localparam int KEY_ROWS    = 29;
  localparam int CFG_IDX_W   = 8;

  // Defaults for the top-level parameters
  localparam int TABLE_ENTRIES_DEF = 29;
  localparam int GROUP_COUNT_DEF   = 3;

  // Input beat: three status words then the tick count
  localparam int IN_DATA_W  = INPUT_GROUPS * WORD_W + WORD_W;
  // Output beat: repeat key, held key, padded to whole bytes
  localparam int OUT_DATA_W = 16;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [DELAY_W-1:0] delay_t;
  typedef logic [GROUP_W-1:0] group_t;
  typedef word_t [MAX_GROUPS-1:0] group_words_t;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_DELAY  = 8'd1;

  localparam delay_t FIRST_DELAY_RST = 16'd500;
  localparam delay_t NEXT_DELAY_RST  = 16'd175;

  localparam word_t WORD_IDLE = '1;  // nothing pressed

  // Result of one table scan
  typedef struct packed {
    key_t clicked_key;
    key_t held_key;
    logic rep_pressed;
  } scan_t;

  // Key table: group, mask and id per row, in priority order
  localparam group_t KEY_GROUP [KEY_ROWS] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2
  };

  localparam key_t KEY_ID [KEY_ROWS] = '{
    5'd1,  5'd2,  5'd1,  5'd3,  5'd1,  5'd4,  5'd5,  5'd6,  5'd5,  5'd7,
    5'd5,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16,
    5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25
  };

  localparam word_t KEY_MASK [KEY_ROWS] = '{
    32'h0000_0001, 32'h0000_0001, 32'h0000_0002, 32'h0000_0002, 32'h0000_0003,
    32'h0000_0003, 32'h0000_0004, 32'h0000_0004, 32'h0000_0008, 32'h0000_0008,
    32'h0000_000C, 32'h0000_000C, 32'h0000_0400, 32'h0000_0800, 32'h0000_1000,
    32'h0000_2000, 32'h0000_4000, 32'h0000_8000, 32'h0001_0000, 32'h0001_0800,
    32'h0002_0000, 32'h0004_0000, 32'h0008_0000, 32'h0020_0000, 32'h0000_0080,
    32'h0000_0100, 32'h0000_2002, 32'h0000_0002, 32'h0000_2000
  };

  // Marks the first row carrying each id; that row decides if the id is held
  function automatic logic [KEY_ROWS-1:0] first_of_id();
    logic [KEY_ROWS-1:0] first;
    first = '1;
    for (int i = 0; i < KEY_ROWS; i++) begin
      for (int j = 0; j < i; j++) begin
        if (KEY_ID[j] == KEY_ID[i]) begin
          first[i] = 1'b0;
        end
      end
    end
    return first;
  endfunction

endpackage

### design/key_scan_autorepeat_unit.sv
// Top level: input register, key word history, config registers and result register.
// A taken beat passes through the input register, then the result register, and
// leaves on m_axis from there. Throughput: one beat per cycle unless m_axis stalls;
// table scan and timer compare are combinational.
// A finished result may wait on m_axis_tready while the next beat is taken in.
// Reset (rst, synchronous): no keys pressed, no repeat key, stamp zero,
// delays 500 ms and 175 ms, both stages empty.
`timescale 1ns / 1ps

module key_scan_autorepeat_unit #(
  parameter int TableEntries = kscan_pkg::TABLE_ENTRIES_DEF,
  parameter int GroupCount   = kscan_pkg::GROUP_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: group0_word, group1_word, group2_word, now_ms
  input  logic [kscan_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: forget_repeat
  input  logic                                s_axis_tuser,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: repeat_key [4:0], held_key [9:5], zero pad
  output logic [kscan_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Config writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kscan_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kscan_pkg::DELAY_W-1:0]       cfg_data
);

  localparam int NowLsb = kscan_pkg::INPUT_GROUPS * kscan_pkg::WORD_W;

  logic                              s1_valid;
  logic [kscan_pkg::IN_DATA_W-1:0]   s1_data;
  logic                              s1_forget;
  logic                              advance;
  kscan_pkg::word_t                  cur_words [GroupCount];
  kscan_pkg::group_words_t           cur_vec;
  kscan_pkg::group_words_t           prev_vec;
  kscan_pkg::delay_t                 first_delay;
  kscan_pkg::delay_t                 next_delay;
  kscan_pkg::scan_t                  scan;
  kscan_pkg::key_t                   rep_id;
  kscan_pkg::key_t                   report;

  // Handshake: stage moves when the result slot is free or being drained
  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign cfg_ready     = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_data   <= s_axis_tdata;
      s1_forget <= s_axis_tuser;
    end
  end

  // Group words for this poll and the previous one; absent groups read idle
  for (genvar g = 0; g < kscan_pkg::MAX_GROUPS; g++) begin : g_grp
    if (g < GroupCount && g < kscan_pkg::INPUT_GROUPS) begin : g_in
      assign cur_vec[g] = s1_data[g*kscan_pkg::WORD_W +: kscan_pkg::WORD_W];
    end else begin : g_idle
      assign cur_vec[g] = kscan_pkg::WORD_IDLE;
    end
    if (g < GroupCount) begin : g_hist
      assign prev_vec[g] = cur_words[g];
      always_ff @(posedge clk) begin
        if (rst) begin
          cur_words[g] <= kscan_pkg::WORD_IDLE;
        end else if (advance) begin
          cur_words[g] <= cur_vec[g];
        end
      end
    end else begin : g_nohist
      assign prev_vec[g] = kscan_pkg::WORD_IDLE;
    end
  end

  // Delay registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay <= kscan_pkg::FIRST_DELAY_RST;
      next_delay  <= kscan_pkg::NEXT_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kscan_pkg::REG_FIRST_DELAY: first_delay <= cfg_data;
        kscan_pkg::REG_NEXT_DELAY:  next_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

  kscan_scan #(
    .TableEntries(TableEntries)
  ) u_scan (
    .cur_words  (cur_vec),
    .prev_words (prev_vec),
    .rep_id     (rep_id),
    .scan       (scan)
  );

  kscan_repeat u_repeat (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .forget      (s1_forget),
    .now_ms      (s1_data[NowLsb +: kscan_pkg::WORD_W]),
    .scan        (scan),
    .first_delay (first_delay),
    .next_delay  (next_delay),
    .rep_id      (rep_id),
    .report      (report)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {{(kscan_pkg::OUT_DATA_W - 2*kscan_pkg::KEY_W){1'b0}},
                       scan.held_key, report};
    end
  end

endmodule

### design/kscan_scan.sv
// Table scan: click detect, first held key and hold check of the repeat key.
`timescale 1ns / 1ps

module kscan_scan #(
  parameter int TableEntries = kscan_pkg::TABLE_ENTRIES_DEF
) (
  input  kscan_pkg::group_words_t cur_words,
  input  kscan_pkg::group_words_t prev_words,
  input  kscan_pkg::key_t         rep_id,
  output kscan_pkg::scan_t        scan
);

  localparam int RowLimit = (TableEntries < kscan_pkg::KEY_ROWS) ?
                            TableEntries : kscan_pkg::KEY_ROWS;
  localparam logic [kscan_pkg::KEY_ROWS-1:0] FirstRow = kscan_pkg::first_of_id();

  logic [kscan_pkg::KEY_ROWS-1:0] cur_hit;
  logic [kscan_pkg::KEY_ROWS-1:0] prev_hit;

  // Per-row press decode: all mask bits low
  always_comb begin
    for (int i = 0; i < kscan_pkg::KEY_ROWS; i++) begin
      cur_hit[i]  = (cur_words[kscan_pkg::KEY_GROUP[i]] & kscan_pkg::KEY_MASK[i]) == '0;
      prev_hit[i] = (prev_words[kscan_pkg::KEY_GROUP[i]] & kscan_pkg::KEY_MASK[i]) == '0;
    end
  end

  // Priority pick, lowest row wins
  always_comb begin
    scan = '0;
    for (int i = RowLimit - 1; i >= 0; i--) begin
      if (cur_hit[i] && !prev_hit[i]) begin
        scan.clicked_key = kscan_pkg::KEY_ID[i];
      end
      if (cur_hit[i]) begin
        scan.held_key = kscan_pkg::KEY_ID[i];
      end
      if (FirstRow[i] && (kscan_pkg::KEY_ID[i] == rep_id) && cur_hit[i]) begin
        scan.rep_pressed = 1'b1;
      end
    end
  end

endmodule

### design/kscan_repeat.sv
// Repeat key state and hold timer.
`timescale 1ns / 1ps

module kscan_repeat (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  forget,
  input  kscan_pkg::word_t      now_ms,
  input  kscan_pkg::scan_t      scan,
  input  kscan_pkg::delay_t     first_delay,
  input  kscan_pkg::delay_t     next_delay,
  output kscan_pkg::key_t       rep_id,
  output kscan_pkg::key_t       report
);

  kscan_pkg::key_t  repeat_id, repeat_id_next;
  kscan_pkg::word_t repeat_stamp, repeat_stamp_next;
  logic             repeating, repeating_next;
  kscan_pkg::word_t diff;
  kscan_pkg::delay_t delay;
  logic             expired;

  // Repeat id as seen by this poll
  assign rep_id = forget ? '0 : repeat_id;

  // Signed elapsed time against the active delay
  assign diff    = now_ms - repeat_stamp;
  assign delay   = repeating ? next_delay : first_delay;
  assign expired = !diff[kscan_pkg::WORD_W-1] &&
                   (diff > {{(kscan_pkg::WORD_W-kscan_pkg::DELAY_W){1'b0}}, delay});

  // Next state and report
  always_comb begin
    repeat_id_next    = rep_id;
    repeat_stamp_next = repeat_stamp;
    repeating_next    = repeating;
    report            = '0;
    if (scan.clicked_key != '0) begin
      repeat_id_next    = scan.clicked_key;
      repeating_next    = 1'b0;
      repeat_stamp_next = now_ms;
      report            = scan.clicked_key;
    end else if (rep_id != '0 && scan.rep_pressed) begin
      if (expired) begin
        repeating_next    = 1'b1;
        repeat_stamp_next = now_ms;
        report            = rep_id;
      end
    end else begin
      repeat_id_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_id    <= '0;
      repeat_stamp <= '0;
      repeating    <= 1'b0;
    end else if (step) begin
      repeat_id    <= repeat_id_next;
      repeat_stamp <= repeat_stamp_next;
      repeating    <= repeating_next;
    end
  end

endmodule

### test/kscan_poll_checker.sv
// Stream monitor for the key scan unit: predicts each result beat and compares it.
`timescale 1ns / 1ps

module kscan_poll_checker #(
  parameter int TableEntries = kscan_pkg::TABLE_ENTRIES_DEF,
  parameter int GroupCount   = kscan_pkg::GROUP_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // tdata: group0_word, group1_word, group2_word, now_ms
  input  logic [kscan_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: forget_repeat
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: repeat_key, held_key, zero pad
  input  logic [kscan_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [kscan_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kscan_pkg::DELAY_W-1:0]     cfg_data,
  output int                                pending,
  output int                                failures
);

  localparam int ScanRows = (TableEntries < kscan_pkg::KEY_ROWS) ?
                            TableEntries : kscan_pkg::KEY_ROWS;
  localparam int KeyW = kscan_pkg::KEY_W;

  typedef struct packed {
    kscan_pkg::key_t rpt_key;
    kscan_pkg::key_t held_key;
  } keys_t;

  // Predicted unit state
  kscan_pkg::word_t  prev_w [kscan_pkg::MAX_GROUPS];
  kscan_pkg::word_t  cur_w  [kscan_pkg::MAX_GROUPS];
  kscan_pkg::key_t   rpt_id;
  kscan_pkg::word_t  rpt_stamp;
  logic              rpt_fast;  // next delay in force
  kscan_pkg::delay_t first_delay;
  kscan_pkg::delay_t next_delay;
  keys_t             expected_keys [$];

  // A row is down when all its mask bits are low; groups past the count never are
  function automatic logic row_is_pressed(input logic in_prev, input int row);
    int               g;
    kscan_pkg::word_t w;
    g = int'(kscan_pkg::KEY_GROUP[row]);
    if (g >= GroupCount) return 1'b0;
    w = in_prev ? prev_w[g] : cur_w[g];
    return (w & kscan_pkg::KEY_MASK[row]) == '0;
  endfunction

  // Held state of an id comes from the first row that carries it
  function automatic logic id_down(input kscan_pkg::key_t id);
    for (int i = 0; i < ScanRows; i++) begin
      if (kscan_pkg::KEY_ID[i] == id) return row_is_pressed(1'b0, i);
    end
    return 1'b0;
  endfunction

  // One poll: shift word history, find click, run repeat timer, find held key
  function automatic keys_t scan_poll(input logic [kscan_pkg::IN_DATA_W-1:0] beat,
                                      input logic forget);
    keys_t             res;
    kscan_pkg::key_t   clicked;
    kscan_pkg::word_t  now;
    kscan_pkg::word_t  diff;
    kscan_pkg::delay_t delay;
    res     = '0;
    clicked = '0;
    now     = beat[kscan_pkg::INPUT_GROUPS*kscan_pkg::WORD_W +: kscan_pkg::WORD_W];
    for (int g = 0; g < kscan_pkg::MAX_GROUPS; g++) begin
      prev_w[g] = cur_w[g];
      cur_w[g]  = (g < GroupCount && g < kscan_pkg::INPUT_GROUPS) ?
                  beat[g*kscan_pkg::WORD_W +: kscan_pkg::WORD_W] : kscan_pkg::WORD_IDLE;
    end
    if (forget) rpt_id = '0;
    for (int i = 0; i < ScanRows; i++) begin
      if (clicked == '0 && !row_is_pressed(1'b1, i) && row_is_pressed(1'b0, i)) begin
        clicked = kscan_pkg::KEY_ID[i];
      end
    end
    if (clicked != '0) begin
      rpt_id      = clicked;
      rpt_fast    = 1'b0;
      rpt_stamp   = now;
      res.rpt_key = clicked;
    end else if (rpt_id != '0 && id_down(rpt_id)) begin
      // wrapped difference, negative never fires
      diff  = now - rpt_stamp;
      delay = rpt_fast ? next_delay : first_delay;
      if (!diff[kscan_pkg::WORD_W-1] &&
          diff > {{(kscan_pkg::WORD_W-kscan_pkg::DELAY_W){1'b0}}, delay}) begin
        rpt_fast    = 1'b1;
        rpt_stamp   = now;
        res.rpt_key = rpt_id;
      end
    end else begin
      rpt_id = '0;
    end
    for (int i = 0; i < ScanRows; i++) begin
      if (res.held_key == '0 && row_is_pressed(1'b0, i)) res.held_key = kscan_pkg::KEY_ID[i];
    end
    return res;
  endfunction

  // Compare result beats first, then predict the beat taken at this edge
  always @(posedge clk) begin
    keys_t want;
    if (rst) begin
      for (int g = 0; g < kscan_pkg::MAX_GROUPS; g++) begin
        prev_w[g] = kscan_pkg::WORD_IDLE;
        cur_w[g]  = kscan_pkg::WORD_IDLE;
      end
      rpt_id      = '0;
      rpt_stamp   = '0;
      rpt_fast    = 1'b0;
      first_delay = kscan_pkg::FIRST_DELAY_RST;
      next_delay  = kscan_pkg::NEXT_DELAY_RST;
      expected_keys.delete();
      failures = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_keys.size() == 0) begin
          $error("result beat with no poll waiting: tdata %h", m_axis_tdata);
          failures++;
        end else begin
          want = expected_keys.pop_front();
          if (m_axis_tdata[KeyW-1:0] !== want.rpt_key) begin
            $error("repeat_key: expected %0d, actual %0d", want.rpt_key,
                   m_axis_tdata[KeyW-1:0]);
            failures++;
          end
          if (m_axis_tdata[2*KeyW-1:KeyW] !== want.held_key) begin
            $error("held_key: expected %0d, actual %0d", want.held_key,
                   m_axis_tdata[2*KeyW-1:KeyW]);
            failures++;
          end
          if (m_axis_tdata[kscan_pkg::OUT_DATA_W-1:2*KeyW] !== '0) begin
            $error("pad: expected 0, actual %h",
                   m_axis_tdata[kscan_pkg::OUT_DATA_W-1:2*KeyW]);
            failures++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_keys.push_back(scan_poll(s_axis_tdata, s_axis_tuser));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kscan_pkg::REG_FIRST_DELAY: first_delay = cfg_data;
          kscan_pkg::REG_NEXT_DELAY:  next_delay  = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= expected_keys.size();
  end

endmodule

### test/key_scan_autorepeat_unit_tb.sv
// Testbench top for the key scan autorepeat unit: poll stimulus, idling and verdict.
`timescale 1ns / 1ps

module key_scan_autorepeat_unit_tb;

  localparam int IdleLimit   = 2000;  // cycles without any beat
  localparam int DrainCycles = 4;
  localparam int PhaseItems  = 130;
  localparam int HoldOff     = 40;

  // Register indexes past the map, writes must be dropped
  localparam logic [kscan_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
  localparam logic [kscan_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [kscan_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                             s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [kscan_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [kscan_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kscan_pkg::DELAY_W-1:0]    cfg_data;

  int                pending;
  int                failures;
  int                idle_cycles = 0;
  int                tx_calm = 0;
  int                rx_calm = 0;
  kscan_pkg::word_t  tick;
  kscan_pkg::delay_t cur_first = kscan_pkg::FIRST_DELAY_RST;
  kscan_pkg::delay_t cur_next  = kscan_pkg::NEXT_DELAY_RST;
  kscan_pkg::word_t  key_bits [kscan_pkg::INPUT_GROUPS];

  key_scan_autorepeat_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  kscan_poll_checker poll_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .failures      (failures)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle cycles before a beat, drawn at random, with runs of back-to-back beats
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Millisecond tick: mostly small steps, sometimes long ones or a jump anywhere
  function automatic kscan_pkg::word_t next_tick(input int span);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) tick = $urandom();
    else if (pick < 8) tick += $urandom_range(0, 4 * span);
    else tick += $urandom_range(0, span);
    return tick;
  endfunction

  task automatic send_poll(input kscan_pkg::word_t g0, input kscan_pkg::word_t g1,
                           input kscan_pkg::word_t g2, input kscan_pkg::word_t now,
                           input logic forget);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, g2, g1, g0};
    s_axis_tuser  <= forget;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering polls until every result beat is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kscan_pkg::CFG_IDX_W-1:0] idx,
                           input kscan_pkg::delay_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input kscan_pkg::delay_t first_ms,
                           input kscan_pkg::delay_t next_ms);
    wait_drained();
    write_reg(kscan_pkg::REG_FIRST_DELAY, first_ms);
    write_reg(kscan_pkg::REG_NEXT_DELAY, next_ms);
    cur_first = first_ms;
    cur_next  = next_ms;
  endtask

  // Random press / hold / release gestures, with bounce and noise polls mixed in
  task automatic run_phase(input int n_items);
    int               sent;
    int               span;
    int               hold;
    int               row;
    int               row2;
    kscan_pkg::word_t w [kscan_pkg::INPUT_GROUPS];
    span = ((cur_first > cur_next) ? cur_first : cur_next) / 2 + 4;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 6) == 0) begin
        for (int g = 0; g < kscan_pkg::INPUT_GROUPS; g++) w[g] = $urandom();
        send_poll(w[0], w[1], w[2], next_tick(span), $urandom_range(0, 19) == 0);
        sent++;
      end else begin
        row  = $urandom_range(0, kscan_pkg::KEY_ROWS - 1);
        hold = $urandom_range(1, 12);
        for (int g = 0; g < kscan_pkg::INPUT_GROUPS; g++) w[g] = kscan_pkg::WORD_IDLE;
        w[kscan_pkg::KEY_GROUP[row]] &= ~kscan_pkg::KEY_MASK[row];
        if ($urandom_range(0, 4) == 0) begin
          row2 = $urandom_range(0, kscan_pkg::KEY_ROWS - 1);
          w[kscan_pkg::KEY_GROUP[row2]] &= ~kscan_pkg::KEY_MASK[row2];
        end
        // toggle bits that no key looks at
        for (int g = 0; g < kscan_pkg::INPUT_GROUPS; g++) begin
          if ($urandom_range(0, 3) == 0) w[g] &= $urandom() | key_bits[g];
        end
        for (int k = 0; k < hold; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE,
                      next_tick(span), 1'b0);
          end else begin
            send_poll(w[0], w[1], w[2], next_tick(span), $urandom_range(0, 19) == 0);
          end
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE,
                    next_tick(span), 1'b0);
          sent++;
        end
      end
    end
  endtask

  // Result side: random stalls, two long hold-offs while polls keep coming
  initial begin
    int gap;
    int beats;
    beats = 0;
    m_axis_tready <= 1'b0;
    forever begin
      if (beats == 250 || beats == 550) gap = HoldOff;
      else gap = draw_gap(rx_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      beats++;
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IdleLimit) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("key_scan_autorepeat_unit_tb: FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= kscan_pkg::REG_FIRST_DELAY;
    cfg_data      <= '0;
    for (int g = 0; g < kscan_pkg::INPUT_GROUPS; g++) key_bits[g] = '0;
    for (int i = 0; i < kscan_pkg::KEY_ROWS; i++) begin
      key_bits[kscan_pkg::KEY_GROUP[i]] |= kscan_pkg::KEY_MASK[i];
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed polls at reset delays: click, first and next repeat edges, forget
    send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd0, 1'b0);
    send_poll(~32'h1, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd200, 1'b0);
    send_poll(~32'h1, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd700, 1'b0);
    send_poll(~32'h1, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd701, 1'b0);
    send_poll(~32'h1, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd876, 1'b0);
    send_poll(~32'h1, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd877, 1'b0);
    send_poll(~32'h1, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd2000, 1'b1);
    send_poll(~32'h1, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd2100, 1'b0);
    // combined display+set, playback, shoot_full then shoot_half alone
    send_poll(~32'h0001_0800, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd2300, 1'b0);
    send_poll(kscan_pkg::WORD_IDLE, ~32'h0020_0000, kscan_pkg::WORD_IDLE, 32'd2400, 1'b0);
    send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, ~32'h0000_2002, 32'd2500, 1'b0);
    send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, ~32'h0000_2000, 32'd3200, 1'b0);
    // everything pressed, then nothing, at the tick extremes
    send_poll('0, '0, '0, 32'hFFFF_FFFF, 1'b0);
    send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd0, 1'b1);
    // id on several rows: first row released drops the repeat key
    send_poll(~32'h0000_000C, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd3000, 1'b0);
    send_poll(~32'h0000_0008, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd9000, 1'b0);
    send_poll(~32'h0000_000C, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, 32'd9100, 1'b0);
    // tick wraps past zero, then a negative difference
    send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE,
              32'hFFFF_FF00, 1'b0);
    send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, ~32'h0000_0100, 32'hFFFF_FF00, 1'b0);
    send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, ~32'h0000_0100, 32'h0000_0100, 1'b0);
    send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, ~32'h0000_0100, 32'h8000_0200, 1'b0);
    send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, ~32'h0000_0100, 32'h0000_01B0, 1'b0);
    send_poll(kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE, kscan_pkg::WORD_IDLE,
              32'h0000_0200, 1'b0);

    // Random phases over several delay settings
    tick = $urandom();
    run_phase(PhaseItems);
    configure(16'd0, 16'd0);
    run_phase(PhaseItems);
    configure(16'hFFFF, 16'hFFFF);
    run_phase(PhaseItems / 2);
    wait_drained();
    run_phase(PhaseItems / 2);
    configure(16'd20, 16'd5);
    write_reg(REG_SPARE_LO, 16'($urandom()));
    write_reg(REG_SPARE_HI, 16'($urandom()));
    tick = 32'hFFFF_FF00;
    run_phase(PhaseItems);
    configure(16'($urandom()), 16'($urandom()));
    run_phase(PhaseItems);
    configure(16'd300, 16'd40);
    run_phase(PhaseItems);

    wait_drained();
    if (failures == 0 && pending == 0) begin
      $display("key_scan_autorepeat_unit_tb: PASS");
    end else begin
      $display("key_scan_autorepeat_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/kscan_pkg.sv
design/kscan_scan.sv
design/kscan_repeat.sv
design/key_scan_autorepeat_unit.sv
test/kscan_poll_checker.sv
test/key_scan_autorepeat_unit_tb.sv
